// File: hw/rtl/q248alu_pkg.sv
// Package for the Q24.8 fixed-point ALU: item types, action and status codes,
// and the word and divider sizes. Used by every module under hw/rtl.
`default_nettype none

package q248alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int ACT_BITS  = 4;
  localparam int PROD_BITS = 2 * WORD_BITS;
  // quotient magnitude bits: |a| << FRAC_BITS
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    act_t  action;
    word_t a_value;
    word_t b_value;
  } in_item_t;

  typedef struct packed {
    word_t   result_value;
    logic    compare_true;
    status_t status;
  } out_item_t;

  // everything an item carries past the divider besides the quotient
  typedef struct packed {
    act_t                        action;
    word_t                       fast_res;
    logic                        fast_ovf;
    logic                        cmp;
    logic signed [PROD_BITS-1:0] prod;
    logic                        neg;
    logic                        div_zero;
  } side_t;

endpackage : q248alu_pkg

`default_nettype wire

// File: hw/rtl/fixed_point_q24_8_alu_core.sv
// Top level of the Q24.8 fixed-point ALU: input register, operand prep,
// divider pipeline (q248alu_div) and result select. Uses q248alu_pkg.
//
//  channel | ports                        | carries
//  --------+------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data  | in_item_t: action, a, b
//  result  | out_valid, out_stall, out_data | out_item_t: result, cmp, status
//
// One item per cycle while the output is not stalled. Stages: input register,
// prep stage with the 32x32 multiplier, 40 divider stages (one quotient bit
// each) and the output register. All stages hold together while a result
// waits stalled. Reset clears the valid bits only; no clearing pass.
`default_nettype none

module fixed_point_q24_8_alu_core
  import q248alu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      en;
  logic      v0_r;
  in_item_t  d0_r;
  logic      v1_r;
  side_t     side1_r;
  logic [QUO_BITS-1:0]  num1_r;
  logic [WORD_BITS-1:0] den1_r;
  logic      dv;
  side_t     dside;
  logic [QUO_BITS-1:0] dquo;
  logic      out_valid_r;
  out_item_t out_data_r;
  side_t     side1_nxt;
  logic [QUO_BITS-1:0]  num1_nxt;
  logic [WORD_BITS-1:0] den1_nxt;
  out_item_t out_nxt;

  // whole pipeline advances unless a finished item is held
  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= in_data;
    end
  end

  // prep: fast (non-divide) ops, product, divider operands
  always_comb begin
    logic signed [WORD_BITS:0] sum;
    logic signed [WORD_BITS:0] addend;
    logic [WORD_BITS-1:0]      abs_a;
    logic [WORD_BITS-1:0]      abs_b;
    logic [FRAC_BITS:0]        top_a;

    side1_nxt          = '0;
    side1_nxt.action   = d0_r.action;
    side1_nxt.prod     = PROD_BITS'(d0_r.a_value) * PROD_BITS'(d0_r.b_value);
    side1_nxt.neg      = d0_r.a_value[WORD_BITS-1] ^ d0_r.b_value[WORD_BITS-1];
    side1_nxt.div_zero = (d0_r.b_value == '0);

    abs_a    = d0_r.a_value[WORD_BITS-1] ? (~d0_r.a_value + 1'b1) : d0_r.a_value;
    abs_b    = d0_r.b_value[WORD_BITS-1] ? (~d0_r.b_value + 1'b1) : d0_r.b_value;
    num1_nxt = {abs_a, {FRAC_BITS{1'b0}}};
    den1_nxt = abs_b;

    // add, sub, inc, dec share one adder
    case (d0_r.action)
      ACT_SUB: addend = -{d0_r.b_value[WORD_BITS-1], d0_r.b_value};
      ACT_INC: addend = (WORD_BITS+1)'(1);
      ACT_DEC: addend = -(WORD_BITS+1)'(1);
      default: addend = {d0_r.b_value[WORD_BITS-1], d0_r.b_value};
    endcase
    sum   = {d0_r.a_value[WORD_BITS-1], d0_r.a_value} + addend;
    top_a = d0_r.a_value[WORD_BITS-1:WORD_BITS-FRAC_BITS-1];

    case (d0_r.action)
      ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
        side1_nxt.fast_res = sum[WORD_BITS-1:0];
        side1_nxt.fast_ovf = sum[WORD_BITS] ^ sum[WORD_BITS-1];
      end
      ACT_GT: side1_nxt.cmp = d0_r.a_value >  d0_r.b_value;
      ACT_LT: side1_nxt.cmp = d0_r.a_value <  d0_r.b_value;
      ACT_GE: side1_nxt.cmp = d0_r.a_value >= d0_r.b_value;
      ACT_LE: side1_nxt.cmp = d0_r.a_value <= d0_r.b_value;
      ACT_EQ: side1_nxt.cmp = d0_r.a_value == d0_r.b_value;
      ACT_NE: side1_nxt.cmp = d0_r.a_value != d0_r.b_value;
      ACT_MIN: side1_nxt.fast_res = (d0_r.b_value < d0_r.a_value) ? d0_r.b_value
                                                                   : d0_r.a_value;
      ACT_MAX: side1_nxt.fast_res = (d0_r.b_value > d0_r.a_value) ? d0_r.b_value
                                                                   : d0_r.a_value;
      ACT_FROM_INT: begin
        side1_nxt.fast_res = {d0_r.a_value[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        side1_nxt.fast_ovf = ~((&top_a) | ~(|top_a));
      end
      ACT_TO_INT: side1_nxt.fast_res = d0_r.a_value >>> FRAC_BITS;
      default: side1_nxt.fast_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      num1_r  <= num1_nxt;
      den1_r  <= den1_nxt;
    end
  end

  q248alu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v1_r),
    .in_side (side1_r),
    .in_num  (num1_r),
    .in_den  (den1_r),
    .out_vld (dv),
    .out_side(dside),
    .out_quo (dquo)
  );

  // result select: product scaling, quotient sign, overflow flags
  always_comb begin
    logic signed [QUO_BITS:0]               sq;
    logic [PROD_BITS-1:WORD_BITS+FRAC_BITS-1] ptop;
    logic [QUO_BITS:WORD_BITS-1]            qtop;
    logic                                   ovf;

    sq   = dside.neg ? -{1'b0, dquo} : {1'b0, dquo};
    ptop = dside.prod[PROD_BITS-1:WORD_BITS+FRAC_BITS-1];
    qtop = sq[QUO_BITS:WORD_BITS-1];
    out_nxt              = '0;
    out_nxt.compare_true = dside.cmp;
    ovf                  = dside.fast_ovf;
    out_nxt.result_value = dside.fast_res;

    case (dside.action)
      ACT_MUL: begin
        out_nxt.result_value = dside.prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
        ovf = ~((&ptop) | ~(|ptop));
      end
      ACT_DIV: begin
        out_nxt.result_value = sq[WORD_BITS-1:0];
        ovf = ~((&qtop) | ~(|qtop));
      end
      default: ;
    endcase

    if (dside.action == ACT_DIV && dside.div_zero) begin
      out_nxt.result_value = '0;
      out_nxt.status       = ST_DIVZERO;
    end else if (ovf) begin
      out_nxt.status = ST_OVERFLOW;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // a divide by zero always comes back as a zero, non-compare result
  a_divzero_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DIVZERO |->
      out_data.result_value == '0 && !out_data.compare_true)
    else $error("divide by zero result not cleared");

  // a true comparison never carries an error status
  a_cmp_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.compare_true |-> out_data.status == ST_OK)
    else $error("comparison with non-ok status");

  // a held result freezes the prep stage as well
  a_hold_prep : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> v1_r == $past(v1_r))
    else $error("prep stage moved during stall");
`endif

endmodule : fixed_point_q24_8_alu_core

`default_nettype wire

// File: hw/rtl/q248alu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on q248alu_pkg for side_t and the divider widths.
`default_nettype none

module q248alu_div
  import q248alu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire side_t                in_side,
  input  wire logic [QUO_BITS-1:0]  in_num,
  input  wire logic [WORD_BITS-1:0] in_den,
  output logic                      out_vld,
  output side_t                     out_side,
  output logic [QUO_BITS-1:0]       out_quo
);

  localparam int DEPTH = QUO_BITS;

  logic                 vld_r  [DEPTH];
  side_t                side_r [DEPTH];
  logic [QUO_BITS-1:0]  num_r  [DEPTH];
  logic [WORD_BITS-1:0] den_r  [DEPTH];
  logic [WORD_BITS-1:0] rem_r  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_stage
    logic                 v_in;
    side_t                s_in;
    logic [QUO_BITS-1:0]  n_in;
    logic [WORD_BITS-1:0] d_in;
    logic [WORD_BITS-1:0] r_in;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS+1:0] trial;
    logic                 ge;
    logic [WORD_BITS-1:0] rem_nxt;
    logic [QUO_BITS-1:0]  num_nxt;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign s_in = in_side;
      assign n_in = in_num;
      assign d_in = in_den;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign s_in = side_r[i-1];
      assign n_in = num_r[i-1];
      assign d_in = den_r[i-1];
      assign r_in = rem_r[i-1];
    end

    // shift in the next dividend bit and try subtracting the divisor
    always_comb begin
      shifted = {r_in, n_in[QUO_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, d_in};
      ge      = ~trial[WORD_BITS+1];
      rem_nxt = ge ? trial[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      num_nxt = {n_in[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= s_in;
        num_r[i]  <= num_nxt;
        den_r[i]  <= d_in;
        rem_r[i]  <= rem_nxt;
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_side = side_r[DEPTH-1];
  assign out_quo  = num_r[DEPTH-1];

endmodule : q248alu_div

`default_nettype wire
